// ===== rtl/core/ccq_pkg.sv =====
// Shared types and constants of the coalescing CAN transmit queue.
package ccq_pkg;

  // Input commands.
  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_ENQUEUE = 2'd1;
  localparam logic [1:0] CMD_POP     = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_APPENDED = 3'd0;
  localparam logic [2:0] ST_UPDATED  = 3'd1;
  localparam logic [2:0] ST_DROPPED  = 3'd2;
  localparam logic [2:0] ST_WORD     = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;

  localparam int STAGE_SLOTS = 8;

  // Stored frame header: id, flags and saturated length.
  typedef struct packed {
    logic [28:0] can_id;
    logic        is_fd;
    logic        bit_rate_switch;
    logic        extended_id;
    logic        remote;
    logic [6:0]  length;
  } hdr_t;

  // Byte-enable mask of payload word w for a frame of len bytes.
  function automatic logic [63:0] byte_mask(input logic [6:0] len, input logic [2:0] w);
    logic [63:0] m;
    logic [7:0]  start;
    m = '0;
    start = {2'b00, w, 3'b000};
    for (int b = 0; b < 8; b++) begin
      if ({1'b0, len} > start + 8'(b)) m[b*8 +: 8] = 8'hFF;
    end
    return m;
  endfunction

endpackage

// ===== rtl/core/ccq_stage.sv =====
// Staging buffer of payload words shared by all channels.
module ccq_stage (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [2:0]  wr_idx,
  input  logic [63:0] wr_data,
  input  logic [2:0]  rd_idx,
  output logic [63:0] rd_data
);
  import ccq_pkg::*;

  logic [63:0] words [STAGE_SLOTS];

  // Reset-cleared register file, read at one selected slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STAGE_SLOTS; i++) words[i] <= '0;
    end else if (wr_en) begin
      words[wr_idx] <= wr_data;
    end
  end

  assign rd_data = words[rd_idx];
endmodule

// ===== rtl/core/ccq_ctrl.sv =====
// Queue sequencer: header and payload memories, pointers, search and pop.
module ccq_ctrl #(
  parameter int QUEUE_DEPTH    = 8,
  parameter int MAX_DATA_BYTES = 64,
  parameter int CHANNELS       = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         cmd,
  input  logic [1:0]         chan,
  input  ccq_pkg::hdr_t      in_hdr,
  input  logic [7:0]         in_len,
  output logic [2:0]         stage_idx,
  input  logic [63:0]        stage_word,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_status,
  output ccq_pkg::hdr_t      out_hdr,
  output logic [2:0]         out_widx,
  output logic [63:0]        out_word,
  output logic               out_last
);
  import ccq_pkg::*;

  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int NW = (MAX_DATA_BYTES + 7) / 8;
  localparam int HD = CHANNELS * QUEUE_DEPTH;
  localparam int HA = $clog2(HD) > 0 ? $clog2(HD) : 1;
  localparam int PA = HA + 3;
  localparam int NT = QW + 1;

  typedef enum logic [2:0] {S_IDLE, S_SREAD, S_SCMP, S_WRITE, S_PREAD, S_PWORD, S_OUT}
    state_t;

  state_t       state;
  hdr_t         hmem [HD];
  logic [63:0]  pmem [HD*8];
  logic [QW-1:0] head [CHANNELS];
  logic [QW-1:0] tail [CHANNELS];
  logic [NT-1:0] count [CHANNELS];

  logic [CW-1:0] ch;
  hdr_t          f;
  logic [NT-1:0] i;
  logic [QW-1:0] slot;
  logic          found;
  logic [2:0]    w, nw_last;
  hdr_t          hrd;
  logic [63:0]   prd;
  logic          pop_mode;

  function automatic logic [QW-1:0] wrap(input logic [QW:0] v);
    logic [QW:0] r;
    r = (v >= (QW+1)'(QUEUE_DEPTH)) ? v - (QW+1)'(QUEUE_DEPTH) : v;
    return r[QW-1:0];
  endfunction

  logic [QW-1:0] probe;
  logic [HA-1:0] haddr;
  logic          ch_ok;
  hdr_t          in_f;

  assign ch_ok = 32'(chan) < CHANNELS;
  assign probe = wrap({1'b0, head[ch]} + (QW+1)'(i));
  assign haddr = HA'(32'(ch) * QUEUE_DEPTH + 32'(state == S_PREAD ? head[ch] : probe));
  assign in_ready = (state == S_IDLE) && !out_valid;
  assign stage_idx = w;

  // Incoming header with the length saturated to the frame size.
  always_comb begin
    in_f = in_hdr;
    in_f.length = (in_len > 8'(MAX_DATA_BYTES)) ? 7'(MAX_DATA_BYTES) : in_len[6:0];
  end

  // Synchronous memory reads, registered into hrd and prd.
  always_ff @(posedge clk) begin
    hrd <= hmem[haddr];
    prd <= pmem[PA'({haddr, 3'b000}) | PA'(w)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        head[c] <= '0; tail[c] <= '0; count[c] <= '0;
      end
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            ch <= CW'(chan);
            f <= in_f;
            i <= '0; w <= '0; found <= 1'b0;
            out_hdr <= '0; out_widx <= '0; out_word <= '0; out_last <= 1'b1;
            if (cmd == CMD_ENQUEUE && ch_ok) begin
              state <= S_SREAD;
            end else if (cmd == CMD_POP) begin
              if (!ch_ok || count[CW'(chan)] == '0) begin
                out_status <= ST_EMPTY;
                out_valid <= 1'b1;
              end else begin
                state <= S_PREAD;
              end
            end
          end
        end
        // Walk the queue from head to tail, one stored key a step.
        S_SREAD: begin
          if (i >= count[ch]) begin
            state <= S_WRITE;
            if (count[ch] >= NT'(QUEUE_DEPTH)) begin
              head[ch] <= wrap({1'b0, head[ch]} + 1'b1);
              count[ch] <= count[ch] - 1'b1;
              out_status <= ST_DROPPED;
            end else begin
              out_status <= ST_APPENDED;
            end
            slot <= tail[ch];
          end else begin
            state <= S_SCMP;
            slot <= probe;
          end
        end
        S_SCMP: begin
          if (hrd.can_id == f.can_id && hrd.extended_id == f.extended_id &&
              hrd.remote == f.remote && hrd.is_fd == f.is_fd) begin
            found <= 1'b1;
            out_status <= ST_UPDATED;
            state <= S_WRITE;
          end else begin
            i <= i + 1'b1;
            state <= S_SREAD;
          end
        end
        // Header write with payload word 0, then one masked payload word per cycle.
        S_WRITE: begin
          if (w == 3'd0) begin
            hmem[HA'(32'(ch) * QUEUE_DEPTH + 32'(slot))] <= f;
            if (!found) begin
              tail[ch] <= wrap({1'b0, slot} + 1'b1);
              count[ch] <= count[ch] + 1'b1;
            end
          end
          pmem[PA'({HA'(32'(ch) * QUEUE_DEPTH + 32'(slot)), 3'b000}) | PA'(w)] <=
            stage_word & byte_mask(f.length, w);
          if (32'(w) == NW - 1) begin
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
          w <= w + 1'b1;
        end
        S_PREAD: begin
          state <= S_PWORD;
        end
        S_PWORD: begin
          if (w == 3'd0) begin
            f <= hrd;
            nw_last <= (hrd.length == '0) ? 3'd0 : 3'((hrd.length - 7'd1) >> 3);
          end
          state <= S_OUT;
          pop_mode <= 1'b1;
        end
        // Present one frame word and advance when it is taken.
        S_OUT: begin
          if (!out_valid && pop_mode) begin
            out_status <= ST_WORD;
            out_hdr <= f;
            out_widx <= w;
            out_word <= prd & byte_mask(f.length, w);
            out_last <= (w == nw_last);
            out_valid <= 1'b1;
            pop_mode <= 1'b0;
            if (w == nw_last) begin
              head[ch] <= wrap({1'b0, head[ch]} + 1'b1);
              count[ch] <= count[ch] - 1'b1;
            end
          end else if (!pop_mode && out_valid && out_ready) begin
            if (out_last) state <= S_IDLE;
            else begin
              w <= w + 1'b1;
              state <= S_PREAD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/core/coalescing_can_tx_queue_unit.sv =====
// Top level of the coalescing CAN transmit queue.
// Items arrive on the s_axis channel: a load stages one payload word, an
// enqueue writes the staged frame into a channel queue, a pop reads the head
// frame out. Results leave on m_axis; tlast marks the final result of an item.
// A load gives no result. An enqueue walks the stored headers from head to
// tail, then writes the header with the first payload word and one payload
// word per cycle after it. A pop reads the header with the first payload word
// and then each further word from the memory, one result per word.
// Only one item is worked on at a time; s_axis_tready is low while busy.
// Reset empties every queue and clears the staged words; frame memories
// keep whatever they hold. When the receiver stalls, the held result stays
// on m_axis and the block waits.
module coalescing_can_tx_queue_unit #(
  parameter int QUEUE_DEPTH    = 8,
  parameter int MAX_DATA_BYTES = 64,
  parameter int CHANNELS       = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // command, channel, can_id, is_fd, bit_rate_switch, extended_id, remote,
  // length, word_index, payload_word; 112 bits in all, no pad
  input  logic [111:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status, out_can_id, out_is_fd, out_bit_rate_switch, out_extended_id,
  // out_remote, out_length, out_word_index, out_payload_word; pad to 112 bits
  output logic [111:0] m_axis_tdata,
  output logic         m_axis_tlast
);
  import ccq_pkg::*;

  hdr_t        in_hdr, out_hdr;
  logic [2:0]  stage_idx, out_widx, out_status;
  logic [63:0] stage_word, out_word;
  logic        load_en;

  assign in_hdr.can_id          = s_axis_tdata[32:4];
  assign in_hdr.is_fd           = s_axis_tdata[33];
  assign in_hdr.bit_rate_switch = s_axis_tdata[34];
  assign in_hdr.extended_id     = s_axis_tdata[35];
  assign in_hdr.remote          = s_axis_tdata[36];
  assign in_hdr.length          = s_axis_tdata[43:37];
  assign load_en = s_axis_tvalid && s_axis_tready && s_axis_tdata[1:0] == CMD_LOAD;

  ccq_stage u_stage (
    .clk(clk), .rst(rst), .wr_en(load_en), .wr_idx(s_axis_tdata[47:45]),
    .wr_data(s_axis_tdata[111:48]), .rd_idx(stage_idx), .rd_data(stage_word)
  );

  ccq_ctrl #(.QUEUE_DEPTH(QUEUE_DEPTH), .MAX_DATA_BYTES(MAX_DATA_BYTES),
             .CHANNELS(CHANNELS)) u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .cmd(s_axis_tdata[1:0]), .chan(s_axis_tdata[3:2]), .in_hdr(in_hdr),
    .in_len(s_axis_tdata[44:37]), .stage_idx(stage_idx), .stage_word(stage_word),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_status(out_status),
    .out_hdr(out_hdr), .out_widx(out_widx), .out_word(out_word), .out_last(m_axis_tlast)
  );

  assign m_axis_tdata = {2'd0, out_word, out_widx, out_hdr.length, out_hdr.remote,
                         out_hdr.extended_id, out_hdr.bit_rate_switch, out_hdr.is_fd,
                         out_hdr.can_id, out_status};
endmodule
